@@ src/mlrr_pkg.sv @@
// Package for the multilevel round-robin scheduler: types, constants, codes.
package mlrr_pkg;

    localparam int NUM_SLOTS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 8;
    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [7:0] MAIN_SLICE = 8'd2;
    localparam logic [7:0] IDLE_SLICE = 8'd1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_RUN    = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_SWITCH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_ASLEEP = 2'd1,
        ST_ACTIVE = 2'd2
    } slot_state_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
    localparam logic [1:0] STAT_LIST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [5:0]        task_id;
        logic signed [3:0] target_level;
        logic [7:0]        slice_request;
    } req_t;

    typedef struct packed {
        logic [5:0] running_task;
        logic [7:0] slice_ticks;
        logic       timer_reload;
        logic       jump_needed;
        logic [5:0] granted_slot;
        logic [1:0] status;
    } rsp_t;

endpackage

@@ src/multilevel_round_robin_scheduler_unit.sv @@
// Multilevel round-robin scheduler, sequenced over a shared list memory and a slot table memory.
//
// One transaction is taken at a time and its result is held in an output register; s_ready stays
// low until that result has been taken. After reset a clearing pass over the NUM_SLOTS entries loads the
// slot table and enters the main and idle tasks before the first transaction is accepted.
// Per transaction: alloc reads the slot table one slot at a time until it finds a free slot;
// run and sleep read the slot entry, then walk the level list entry by entry to find and
// compact it, and a sleep that hits the running task rescans the levels; switch advances the
// round robin, and rescans the levels when a pending level change forces it.
// Both memories are single-write, single-read with registered read data.
module multilevel_round_robin_scheduler_unit #(
    parameter int NUM_SLOTS  = mlrr_pkg::NUM_SLOTS_DEF,
    parameter int NUM_LEVELS = mlrr_pkg::NUM_LEVELS_DEF,
    parameter int LIST_DEPTH = mlrr_pkg::LIST_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mlrr_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mlrr_pkg::rsp_t m_data
);
    import mlrr_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SCW = $clog2(NUM_SLOTS + 1);
    localparam int LCW = $clog2(NUM_LEVELS + 1);
    localparam int MW = LW + DW;
    localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);
    localparam logic [5:0] MAIN_TASK = 6'd0;
    localparam logic [5:0] IDLE_TASK = 6'd1;

    typedef enum logic [13:0] {
        S_INIT    = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_ALLOC   = 14'b00000000000100,
        S_ALLOCW  = 14'b00000000001000,
        S_SLOTRD  = 14'b00000000010000,
        S_RUN     = 14'b00000000100000,
        S_FIND    = 14'b00000001000000,
        S_FINDW   = 14'b00000010000000,
        S_SHIFT   = 14'b00000100000000,
        S_SHIFTW  = 14'b00001000000000,
        S_RESCAN  = 14'b00010000000000,
        S_RDCUR   = 14'b00100000000000,
        S_RDWAIT  = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    typedef struct packed {
        slot_state_t     st;
        logic [LW-1:0]   lvl;
        logic [7:0]      slc;
    } slot_t;

    state_t state_reg;

    logic [5:0]       list_mem [NUM_LEVELS*LIST_DEPTH];
    logic [MW-1:0]    rd_addr;
    logic [5:0]       rd_data_reg;
    logic             wr_en;
    logic [MW-1:0]    wr_addr;
    logic [5:0]       wr_data;

    slot_t            slot_mem [NUM_SLOTS];
    logic [SW-1:0]    slot_rd_addr;
    slot_t            slot_rd_reg;
    logic             slot_wr_en;
    logic [SW-1:0]    slot_wr_addr;
    slot_t            slot_wr_data;
    slot_t            slot_init;

    logic [CW-1:0]    cnt_reg   [NUM_LEVELS];
    logic [DW-1:0]    pos_reg   [NUM_LEVELS];
    logic [LW-1:0]    cur_lvl_reg;
    logic             pend_reg;

    req_t             req_reg;
    rsp_t             rsp_reg;
    logic             out_valid_reg;
    logic [SCW-1:0]   idx_reg;      // slot scan / list index
    logic [LCW-1:0]   lscan_reg;
    logic [LW-1:0]    lvl_reg;      // list being edited
    logic [LW-1:0]    newlvl_reg;
    logic             add_after_reg;
    logic             is_sleep_reg;
    logic             cur_hit_reg;  // sleeping task was running
    logic             switch_reg;
    logic [5:0]       old_task_reg;
    logic             old_valid_reg;

    logic [SW-1:0]    tid;
    logic             tid_ok;

    always_comb begin
        tid    = SW'(req_reg.task_id);
        tid_ok = {26'd0, req_reg.task_id} < 32'(NUM_SLOTS);
    end

    function automatic logic [MW-1:0] maddr(input logic [LW-1:0] l, input logic [DW-1:0] i);
        maddr = {l, i};
    endfunction

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = rsp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) list_mem[wr_addr] <= wr_data;
        rd_data_reg <= list_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (slot_wr_en) slot_mem[slot_wr_addr] <= slot_wr_data;
        slot_rd_reg <= slot_mem[slot_rd_addr];
    end

    logic [CW-1:0] cnt_l;
    logic [DW-1:0] pos_l;
    logic [CW-1:0] cnt_c;
    logic [DW-1:0] pos_c;
    assign cnt_l = cnt_reg[lvl_reg];
    assign pos_l = pos_reg[lvl_reg];
    assign cnt_c = cnt_reg[cur_lvl_reg];
    assign pos_c = pos_reg[cur_lvl_reg];

    logic [LW-1:0] req_lvl;
    always_comb begin
        if (req_reg.target_level[3])
            req_lvl = slot_rd_reg.lvl;
        else if ({28'd0, req_reg.target_level} >= 32'(NUM_LEVELS))
            req_lvl = LAST_LVL;
        else
            req_lvl = LW'(req_reg.target_level);
    end

    logic need_add;
    logic lvl_full;
    assign need_add = (slot_rd_reg.st != ST_ACTIVE) || (slot_rd_reg.lvl != req_lvl);
    assign lvl_full = cnt_reg[req_lvl] >= CW'(LIST_DEPTH);

    // combinational read address, write port
    always_comb begin
        rd_addr = maddr(cur_lvl_reg, pos_c);
        wr_en   = 1'b0;
        wr_addr = maddr(lvl_reg, DW'(idx_reg));
        wr_data = 6'(req_reg.task_id);
        if (!aresetn) begin
            wr_en = 1'b0;
        end else if (state_reg == S_INIT) begin
            wr_en   = idx_reg < SCW'(2);
            wr_addr = (idx_reg == '0) ? maddr('0, '0) : maddr(LAST_LVL, '0);
            wr_data = (idx_reg == '0) ? MAIN_TASK : IDLE_TASK;
        end else if (state_reg == S_FIND || state_reg == S_SHIFT) begin
            rd_addr = maddr(lvl_reg, DW'(idx_reg));
        end else if (state_reg == S_SHIFTW) begin
            wr_en   = 1'b1;
            wr_addr = maddr(lvl_reg, DW'(idx_reg - SCW'(1)));
            wr_data = rd_data_reg;
        end else if (state_reg == S_RUN && add_after_reg && !is_sleep_reg
                     && cnt_reg[newlvl_reg] < CW'(LIST_DEPTH) && idx_reg == '0) begin
            wr_en   = 1'b1;
            wr_addr = maddr(newlvl_reg, DW'(cnt_reg[newlvl_reg]));
        end
    end

    always_comb begin
        slot_init.st  = (idx_reg < SCW'(2)) ? ST_ACTIVE : ST_FREE;
        slot_init.lvl = (idx_reg == SCW'(1)) ? LAST_LVL : '0;
        slot_init.slc = (idx_reg == '0) ? MAIN_SLICE
                      : (idx_reg == SCW'(1)) ? IDLE_SLICE : 8'd0;
    end

    always_comb begin
        slot_rd_addr = tid;
        if (state_reg == S_ALLOC)
            slot_rd_addr = SW'(idx_reg);
        else if (state_reg == S_RDWAIT)
            slot_rd_addr = SW'(rd_data_reg);
    end

    // slot entry gets its final value in one write
    always_comb begin
        slot_wr_en   = 1'b0;
        slot_wr_addr = tid;
        slot_wr_data = slot_rd_reg;
        if (!aresetn) begin
            slot_wr_en = 1'b0;
        end else if (state_reg == S_INIT) begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = SW'(idx_reg);
            slot_wr_data = slot_init;
        end else if (state_reg == S_ALLOCW && slot_rd_reg.st == ST_FREE) begin
            slot_wr_en      = 1'b1;
            slot_wr_addr    = SW'(idx_reg);
            slot_wr_data.st = ST_ASLEEP;
        end else if (state_reg == S_RUN && !add_after_reg) begin
            if (req_reg.opcode == OP_SLEEP) begin
                if (slot_rd_reg.st == ST_ACTIVE) begin
                    slot_wr_en      = 1'b1;
                    slot_wr_data.st = ST_ASLEEP;
                end
            end else if (!(need_add && lvl_full)) begin
                slot_wr_en       = 1'b1;
                slot_wr_data.st  = ST_ACTIVE;
                slot_wr_data.lvl = req_lvl;
                if (req_reg.slice_request != 8'd0)
                    slot_wr_data.slc = req_reg.slice_request;
            end
        end
    end

    // add_after_reg marks the add step in S_RUN; the add write also requires idx_reg==0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_lvl_reg   <= '0;
            pend_reg      <= 1'b1;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                cnt_reg[i] <= (i == 0 || i == NUM_LEVELS - 1) ? CW'(1) : '0;
                pos_reg[i] <= '0;
            end
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: begin
                    if (idx_reg == SCW'(NUM_SLOTS - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg <= idx_reg + SCW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg       <= s_data;
                        rsp_reg       <= '0;
                        idx_reg       <= '0;
                        add_after_reg <= 1'b0;
                        is_sleep_reg  <= 1'b0;
                        cur_hit_reg   <= 1'b0;
                        switch_reg    <= 1'b0;
                        unique case (opcode_t'(s_data.opcode))
                            OP_ALLOC:  state_reg <= S_ALLOC;
                            OP_RUN:    state_reg <= S_SLOTRD;
                            OP_SLEEP:  state_reg <= S_SLOTRD;
                            OP_SWITCH: state_reg <= S_RDCUR;
                            default:   state_reg <= S_OUT;
                        endcase
                    end
                end
                S_ALLOC: begin
                    if (idx_reg >= SCW'(NUM_SLOTS)) begin
                        rsp_reg.status <= STAT_NO_SLOT;
                        state_reg      <= S_RDCUR;
                    end else begin
                        state_reg <= S_ALLOCW;
                    end
                end
                S_ALLOCW: begin
                    if (slot_rd_reg.st == ST_FREE) begin
                        rsp_reg.granted_slot <= 6'(idx_reg);
                        state_reg            <= S_RDCUR;
                    end else begin
                        idx_reg   <= idx_reg + SCW'(1);
                        state_reg <= S_ALLOC;
                    end
                end
                S_SLOTRD: begin
                    state_reg <= tid_ok ? S_RUN : S_RDCUR;
                end
                S_RUN: begin
                    // decode run/sleep; also return point after removal
                    if (add_after_reg) begin
                        // add into newlvl (write port active this cycle)
                        if (cnt_reg[newlvl_reg] < CW'(LIST_DEPTH))
                            cnt_reg[newlvl_reg] <= cnt_reg[newlvl_reg] + CW'(1);
                        add_after_reg  <= 1'b0;
                        state_reg      <= S_RDCUR;
                    end else if (req_reg.opcode == OP_SLEEP) begin
                        if (slot_rd_reg.st == ST_ACTIVE) begin
                            is_sleep_reg <= 1'b1;
                            lvl_reg      <= slot_rd_reg.lvl;
                            cur_hit_reg  <= 1'b0;
                            state_reg    <= S_FIND;
                            idx_reg      <= '0;
                            old_valid_reg <= {1'b0, pos_c} < cnt_c;
                        end else begin
                            state_reg <= S_RDCUR;
                        end
                    end else if (need_add && lvl_full) begin
                        rsp_reg.status <= STAT_LIST_FULL;
                        state_reg      <= S_RDCUR;
                    end else begin
                        pend_reg <= 1'b1;
                        if (slot_rd_reg.st != ST_ACTIVE) begin
                            newlvl_reg    <= req_lvl;
                            add_after_reg <= 1'b1;
                            idx_reg       <= '0;
                        end else if (need_add) begin
                            newlvl_reg    <= req_lvl;
                            lvl_reg       <= slot_rd_reg.lvl;
                            idx_reg       <= '0;
                            state_reg     <= S_FIND;
                        end else begin
                            state_reg <= S_RDCUR;
                        end
                    end
                end
                S_FIND: begin
                    if (idx_reg >= SCW'(cnt_l)) begin
                        state_reg <= is_sleep_reg ? S_RDCUR : S_RUN;
                        if (!is_sleep_reg) add_after_reg <= 1'b1;
                        idx_reg <= '0;
                    end else begin
                        state_reg <= S_FINDW;
                    end
                end
                S_FINDW: begin
                    if (rd_data_reg == req_reg.task_id) begin
                        cnt_reg[lvl_reg] <= cnt_l - CW'(1);
                        if (is_sleep_reg && lvl_reg == cur_lvl_reg && old_valid_reg
                            && DW'(idx_reg) == pos_l)
                            cur_hit_reg <= 1'b1;
                        begin
                            logic [DW-1:0] np;
                            np = pos_l;
                            if (DW'(idx_reg) < pos_l) np = pos_l - DW'(1);
                            if ({1'b0, np} >= cnt_l - CW'(1)) np = '0;
                            pos_reg[lvl_reg] <= np;
                        end
                        idx_reg   <= idx_reg + SCW'(1);
                        state_reg <= S_SHIFT;
                    end else begin
                        idx_reg   <= idx_reg + SCW'(1);
                        state_reg <= S_FIND;
                    end
                end
                S_SHIFT: begin
                    // cnt_l already decremented; move entry idx down to idx-1
                    if (idx_reg > SCW'(cnt_l)) begin
                        idx_reg <= '0;
                        if (is_sleep_reg) begin
                            state_reg <= cur_hit_reg ? S_RESCAN : S_RDCUR;
                            lscan_reg <= '0;
                        end else begin
                            add_after_reg <= 1'b1;
                            state_reg     <= S_RUN;
                        end
                    end else begin
                        state_reg <= S_SHIFTW;
                    end
                end
                S_SHIFTW: begin
                    idx_reg   <= idx_reg + SCW'(1);
                    state_reg <= S_SHIFT;
                end
                S_RESCAN: begin
                    if (lscan_reg >= LCW'(NUM_LEVELS)) begin
                        cur_lvl_reg <= LAST_LVL;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_RDCUR;
                    end else if (cnt_reg[LW'(lscan_reg)] != '0) begin
                        cur_lvl_reg <= LW'(lscan_reg);
                        pend_reg    <= 1'b0;
                        state_reg   <= S_RDCUR;
                    end else begin
                        lscan_reg <= lscan_reg + LCW'(1);
                    end
                end
                S_RDCUR: begin
                    // switch: first pass captures the old task
                    if (req_reg.opcode == OP_SWITCH && !switch_reg) begin
                        switch_reg    <= 1'b1;
                        old_valid_reg <= {1'b0, pos_c} < cnt_c;
                        state_reg     <= S_RDWAIT;
                    end else begin
                        state_reg <= S_RDWAIT;
                    end
                end
                S_RDWAIT: begin
                    if (req_reg.opcode == OP_SWITCH && switch_reg && !is_sleep_reg) begin
                        // advance round robin then maybe rescan
                        old_task_reg <= rd_data_reg;
                        is_sleep_reg <= 1'b1; // reuse: second pass marker
                        if ({1'b0, pos_c} + CW'(1) >= cnt_c)
                            pos_reg[cur_lvl_reg] <= '0;
                        else
                            pos_reg[cur_lvl_reg] <= pos_c + DW'(1);
                        lscan_reg <= '0;
                        state_reg <= pend_reg ? S_RESCAN : S_RDCUR;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if ({1'b0, pos_c} < cnt_c) begin
                        rsp_reg.running_task <= rd_data_reg;
                        rsp_reg.slice_ticks  <= slot_rd_reg.slc;
                        if (req_reg.opcode == OP_SWITCH) begin
                            rsp_reg.timer_reload <= 1'b1;
                            rsp_reg.jump_needed  <= !old_valid_reg
                                                    || rd_data_reg != old_task_reg;
                        end else if (cur_hit_reg) begin
                            rsp_reg.jump_needed <= 1'b1;
                        end
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    ap_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    ap_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result before work");
    ap_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> cnt_c <= CW'(LIST_DEPTH))
        else $error("count overflow");

endmodule
